@@ hw/rtl/hgbp_pkg.sv @@
package hgbp_pkg;

	// predictor mode codes (mode register)
	localparam logic [1:0] MODE_BIMODAL = 2'd0;
	localparam logic [1:0] MODE_GSHARE  = 2'd1;
	localparam logic [1:0] MODE_HYBRID  = 2'd2;

	// configuration register indexes
	localparam int unsigned REG_ADDR_W = 3;
	localparam logic [REG_ADDR_W-1:0] REG_MODE          = 3'd0;
	localparam logic [REG_ADDR_W-1:0] REG_CHOOSER_BITS  = 3'd1;
	localparam logic [REG_ADDR_W-1:0] REG_GSHARE_BITS   = 3'd2;
	localparam logic [REG_ADDR_W-1:0] REG_HISTORY_BITS  = 3'd3;
	localparam logic [REG_ADDR_W-1:0] REG_BIMODAL_BITS  = 3'd4;

	localparam int unsigned CFG_DATA_W = 4;

	// counter reset values
	localparam logic [1:0] CNT_RESET_PRED    = 2'd2;
	localparam logic [1:0] CNT_RESET_CHOOSER = 2'd1;

	typedef logic [1:0] ctr_t;

	// 2-bit saturating counter step
	function automatic ctr_t sat_move(input ctr_t c, input logic up);
		ctr_t r;
		r = c;
		if (up) begin
			if (c != 2'd3) r = c + 2'd1;
		end else begin
			if (c != 2'd0) r = c - 2'd1;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/hybrid_gshare_bimodal_predictor.sv @@
// Tournament branch predictor with a bimodal table, a gshare table and a
// chooser table, each 2^MAX_INDEX_BITS two-bit counters held in a simple
// dual-port synchronous memory (one read and one write per clock). Send one
// beat per branch (address and actual
// outcome); one beat comes back per branch with the prediction, a mispredict
// flag and which component predicted. The block takes one branch every cycle
// while the result side keeps up: the tables are read at the input beat into
// stage 1, modified and written back as the branch leaves stage 1, and a
// same-entry update from the branch just ahead is forwarded so back-to-back
// branches see each other's training. The result passes from stage 1 into an
// output register, so a new branch is still taken while a result waits.
// After reset the block sweeps the reset values into all 2^MAX_INDEX_BITS
// entries (4096 at the default) of each table with s_axis_tready low;
// configuration writes are taken during that sweep. Write configuration only
// while no branch is in flight.
module hybrid_gshare_bimodal_predictor #(
	parameter int unsigned MAX_INDEX_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	// input beat
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [31:0] branch_address, [32] taken, rest zero
	// result beat
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [0] predicted_taken, [1] mispredicted,
	                                    // [2] used_gshare, rest zero
	// configuration writes
	input  logic                               cfg_we,
	input  logic [hgbp_pkg::REG_ADDR_W-1:0]    cfg_addr,
	input  logic [hgbp_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int unsigned IW    = MAX_INDEX_BITS;
	localparam int unsigned DEPTH = 1 << MAX_INDEX_BITS;
	// width of an index-bit count (0..MAX_INDEX_BITS)
	localparam int unsigned CW    = $clog2(MAX_INDEX_BITS + 1);
	localparam int unsigned LW    = (CW > hgbp_pkg::CFG_DATA_W) ? CW : hgbp_pkg::CFG_DATA_W;

	// configuration registers
	logic [1:0]                       mode_q;
	logic [hgbp_pkg::CFG_DATA_W-1:0]  chooser_bits_q;
	logic [hgbp_pkg::CFG_DATA_W-1:0]  gshare_bits_q;
	logic [hgbp_pkg::CFG_DATA_W-1:0]  history_bits_q;
	logic [hgbp_pkg::CFG_DATA_W-1:0]  bimodal_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= hgbp_pkg::MODE_HYBRID;
			chooser_bits_q <= 4'd8;
			gshare_bits_q  <= 4'd9;
			history_bits_q <= 4'd6;
			bimodal_bits_q <= 4'd7;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				hgbp_pkg::REG_MODE:         mode_q         <= cfg_data[1:0];
				hgbp_pkg::REG_CHOOSER_BITS: chooser_bits_q <= cfg_data;
				hgbp_pkg::REG_GSHARE_BITS:  gshare_bits_q  <= cfg_data;
				hgbp_pkg::REG_HISTORY_BITS: history_bits_q <= cfg_data;
				hgbp_pkg::REG_BIMODAL_BITS: bimodal_bits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// index widths, saturated to the table size
	logic [CW-1:0] k_w, m1_w, m2_w, n_w, gsh_shift;

	always_comb begin
		k_w  = (LW'(chooser_bits_q) > LW'(MAX_INDEX_BITS)) ? CW'(MAX_INDEX_BITS)
		                                                  : CW'(chooser_bits_q);
		m1_w = (LW'(gshare_bits_q) > LW'(MAX_INDEX_BITS)) ? CW'(MAX_INDEX_BITS)
		                                                 : CW'(gshare_bits_q);
		m2_w = (LW'(bimodal_bits_q) > LW'(MAX_INDEX_BITS)) ? CW'(MAX_INDEX_BITS)
		                                                  : CW'(bimodal_bits_q);
		// history never longer than the gshare index
		n_w  = (LW'(history_bits_q) > LW'(m1_w)) ? m1_w : CW'(history_bits_q);
		gsh_shift = m1_w - n_w;
	end

	// reset sweep over the tables
	logic          clr_busy_q;
	logic [IW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == {IW{1'b1}}) clr_busy_q <= 1'b0;
		end
	end

	// pipeline control
	logic v_s1;
	logic out_v_q;
	logic s1_adv;
	logic in_acc;

	assign s1_adv        = v_s1 && (!out_v_q || m_axis_tready);
	assign s_axis_tready = !clr_busy_q && (!v_s1 || s1_adv);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// index computation at the input beat
	logic [IW-1:0] hist_q;
	logic [IW-1:0] pc;
	logic [IW-1:0] mask_k, mask_m1, mask_m2, mask_n;
	logic [IW-1:0] hist;
	logic [IW-1:0] bi_nxt, gi_nxt, ci_nxt;
	logic [IW-1:0] hist_nxt;
	logic          taken_in;

	always_comb begin
		pc       = s_axis_tdata[IW+1:2];
		taken_in = s_axis_tdata[32];
		mask_k   = ~({IW{1'b1}} << k_w);
		mask_m1  = ~({IW{1'b1}} << m1_w);
		mask_m2  = ~({IW{1'b1}} << m2_w);
		mask_n   = ~({IW{1'b1}} << n_w);
		hist     = hist_q & mask_n;
		bi_nxt   = pc & mask_m2;
		ci_nxt   = pc & mask_k;
		// history sits at the top of the gshare index
		gi_nxt   = ((pc & mask_m1) ^ (hist << gsh_shift)) & mask_m1;
		if (n_w == '0) begin
			hist_nxt = '0;
		end else begin
			hist_nxt = ((hist >> 1) | (IW'(taken_in) << (n_w - 1'b1))) & mask_n;
		end
	end

	// history depends only on outcomes, so it moves at the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (in_acc) begin
			hist_q <= hist_nxt;
		end
	end

	// stage 1 registers
	logic [IW-1:0]        bi_s1, gi_s1, ci_s1;
	logic                 taken_s1;
	logic                 b_fwd_s1, g_fwd_s1, c_fwd_s1;
	hgbp_pkg::ctr_t       b_fwd_d_s1, g_fwd_d_s1, c_fwd_d_s1;

	// table read data
	hgbp_pkg::ctr_t b_rd_q, g_rd_q, c_rd_q;

	// stage 1 read-modify-write
	hgbp_pkg::ctr_t b_cnt, g_cnt, c_cnt;
	hgbp_pkg::ctr_t b_new, g_new, c_new;
	logic           bpred, gpred, use_g, pred;

	always_comb begin
		// same-entry update written at the read edge is not in the read data
		b_cnt = b_fwd_s1 ? b_fwd_d_s1 : b_rd_q;
		g_cnt = g_fwd_s1 ? g_fwd_d_s1 : g_rd_q;
		c_cnt = c_fwd_s1 ? c_fwd_d_s1 : c_rd_q;
		bpred = b_cnt[1];
		gpred = g_cnt[1];
		unique case (mode_q)
			hgbp_pkg::MODE_BIMODAL: use_g = 1'b0;
			hgbp_pkg::MODE_GSHARE:  use_g = 1'b1;
			default:                use_g = c_cnt[1];  // hybrid and unused code
		endcase
		pred  = use_g ? gpred : bpred;
		// only the chosen component trains
		b_new = use_g ? b_cnt : hgbp_pkg::sat_move(b_cnt, taken_s1);
		g_new = use_g ? hgbp_pkg::sat_move(g_cnt, taken_s1) : g_cnt;
		// chooser trains in hybrid and the unused code when the components disagree
		if (mode_q[1] && (bpred != gpred)) begin
			c_new = hgbp_pkg::sat_move(c_cnt, gpred == taken_s1);
		end else begin
			c_new = c_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	// an accept with a valid stage 1 always coincides with its write-back
	always_ff @(posedge clk) begin
		if (in_acc) begin
			bi_s1      <= bi_nxt;
			gi_s1      <= gi_nxt;
			ci_s1      <= ci_nxt;
			taken_s1   <= taken_in;
			b_fwd_s1   <= v_s1 && (bi_nxt == bi_s1);
			g_fwd_s1   <= v_s1 && (gi_nxt == gi_s1);
			c_fwd_s1   <= v_s1 && (ci_nxt == ci_s1);
			b_fwd_d_s1 <= b_new;
			g_fwd_d_s1 <= g_new;
			c_fwd_d_s1 <= c_new;
		end
	end

	// memory write port: reset sweep, then write-back from stage 1
	logic           mem_we;
	logic [IW-1:0]  b_wa, g_wa, c_wa;
	hgbp_pkg::ctr_t b_wd, g_wd, c_wd;

	always_comb begin
		if (clr_busy_q) begin
			mem_we = 1'b1;
			b_wa   = clr_cnt_q;
			g_wa   = clr_cnt_q;
			c_wa   = clr_cnt_q;
			b_wd   = hgbp_pkg::CNT_RESET_PRED;
			g_wd   = hgbp_pkg::CNT_RESET_PRED;
			c_wd   = hgbp_pkg::CNT_RESET_CHOOSER;
		end else begin
			mem_we = s1_adv;
			b_wa   = bi_s1;
			g_wa   = gi_s1;
			c_wa   = ci_s1;
			b_wd   = b_new;
			g_wd   = g_new;
			c_wd   = c_new;
		end
	end

	hgbp_pkg::ctr_t bim_mem [DEPTH];
	hgbp_pkg::ctr_t gsh_mem [DEPTH];
	hgbp_pkg::ctr_t cho_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (mem_we) bim_mem[b_wa] <= b_wd;
		if (in_acc) b_rd_q <= bim_mem[bi_nxt];
	end

	always_ff @(posedge clk) begin
		if (mem_we) gsh_mem[g_wa] <= g_wd;
		if (in_acc) g_rd_q <= gsh_mem[gi_nxt];
	end

	always_ff @(posedge clk) begin
		if (mem_we) cho_mem[c_wa] <= c_wd;
		if (in_acc) c_rd_q <= cho_mem[ci_nxt];
	end

	// output register
	logic out_pred_q, out_misp_q, out_used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_adv) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_pred_q <= pred;
			out_misp_q <= pred ^ taken_s1;
			out_used_q <= use_g;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {5'd0, out_used_q, out_misp_q, out_pred_q};

`ifndef SYNTH
	// nothing is in flight while the tables are being swept
	a_clr_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (!v_s1 && !out_v_q))
		else $error("branch in flight during table sweep");

	// a retiring branch always lands in the output register
	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_v_q)
		else $error("stage 1 result lost");

	// a stalled stage 1 keeps its table indexes
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !s1_adv) |=> (v_s1 && $stable(bi_s1) && $stable(gi_s1) && $stable(ci_s1)))
		else $error("stage 1 changed while stalled");

	// bimodal-only mode never reports gshare
	a_mode_bim: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && (mode_q == hgbp_pkg::MODE_BIMODAL)) |=> !out_used_q)
		else $error("gshare used in bimodal mode");
`endif

endmodule

@@ tb/hgbp_branch_checker.sv @@
`timescale 1ns / 1ps

module hgbp_branch_checker #(
	parameter int unsigned MAX_INDEX_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [39:0]                     s_axis_tdata,   // [31:0] branch_address, [32] taken
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [7:0]                      m_axis_tdata,   // [0] predicted_taken,
	                                                        // [1] mispredicted, [2] used_gshare
	input  logic                            cfg_we,
	input  logic [hgbp_pkg::REG_ADDR_W-1:0] cfg_addr,
	input  logic [hgbp_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              pending,
	output int                              branches_seen,
	output int                              miss_count,
	output int                              gshare_count
);

	localparam int unsigned DEPTH = 1 << MAX_INDEX_BITS;
	localparam int unsigned REPORT_LIMIT = 10;

	typedef struct packed {
		logic predicted_taken;
		logic mispredicted;
		logic used_gshare;
	} branch_result_t;

	logic [1:0] mode_r;
	logic [3:0] chooser_bits_r;
	logic [3:0] gshare_bits_r;
	logic [3:0] history_bits_r;
	logic [3:0] bimodal_bits_r;

	logic [1:0] gshare_tbl [DEPTH];
	logic [1:0] bimodal_tbl [DEPTH];
	logic [1:0] chooser_tbl [DEPTH];
	logic [MAX_INDEX_BITS-1:0] ghist;

	branch_result_t result_q [$];
	branch_result_t want;
	branch_result_t got;
	int results_seen;

	function automatic int unsigned clamp_width(input logic [3:0] b);
		return (b > MAX_INDEX_BITS) ? MAX_INDEX_BITS : b;
	endfunction

	function automatic int unsigned low_ones(input int unsigned b);
		return (b >= 32) ? 32'hffff_ffff : ((32'd1 << b) - 32'd1);
	endfunction

	function automatic logic [1:0] bump(input logic [1:0] c, input logic up);
		if (up)
			return (c == 2'd3) ? c : c + 2'd1;
		return (c == 2'd0) ? c : c - 2'd1;
	endfunction

	// look up all three tables, then train them and shift the history
	function automatic branch_result_t predict_and_train(input logic [31:0] addr,
	                                                     input logic tkn);
		int unsigned k, m1, m2, n, pc, hist, bi, gi, ci;
		logic bp, gp, use_g, pred;
		branch_result_t r;
		k    = clamp_width(chooser_bits_r);
		m1   = clamp_width(gshare_bits_r);
		m2   = clamp_width(bimodal_bits_r);
		n    = (history_bits_r > m1) ? m1 : history_bits_r;
		pc   = addr >> 2;
		hist = ghist & low_ones(n);
		bi   = pc & low_ones(m2);
		gi   = ((pc & low_ones(m1)) ^ (hist << (m1 - n))) & low_ones(m1);
		ci   = pc & low_ones(k);
		bp   = bimodal_tbl[bi] >= 2'd2;
		gp   = gshare_tbl[gi] >= 2'd2;
		case (mode_r)
			hgbp_pkg::MODE_BIMODAL: use_g = 1'b0;
			hgbp_pkg::MODE_GSHARE:  use_g = 1'b1;
			default:                use_g = chooser_tbl[ci] >= 2'd2;
		endcase
		pred = use_g ? gp : bp;
		if (use_g)
			gshare_tbl[gi] = bump(gshare_tbl[gi], tkn);
		else
			bimodal_tbl[bi] = bump(bimodal_tbl[bi], tkn);
		if (mode_r != hgbp_pkg::MODE_BIMODAL && mode_r != hgbp_pkg::MODE_GSHARE &&
		    bp != gp)
			chooser_tbl[ci] = bump(chooser_tbl[ci], gp == tkn);
		if (n == 0)
			ghist = '0;
		else
			ghist = MAX_INDEX_BITS'(((hist >> 1) | ((tkn ? 32'd1 : 32'd0) << (n - 1)))
			                        & low_ones(n));
		r.predicted_taken = pred;
		r.mispredicted    = pred != tkn;
		r.used_gshare     = use_g;
		return r;
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%0t: %s", $realtime, msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_r         = hgbp_pkg::MODE_HYBRID;
			chooser_bits_r = 4'd8;
			gshare_bits_r  = 4'd9;
			history_bits_r = 4'd6;
			bimodal_bits_r = 4'd7;
			for (int i = 0; i < DEPTH; i++) begin
				gshare_tbl[i]  = hgbp_pkg::CNT_RESET_PRED;
				bimodal_tbl[i] = hgbp_pkg::CNT_RESET_PRED;
				chooser_tbl[i] = hgbp_pkg::CNT_RESET_CHOOSER;
			end
			ghist = '0;
			result_q.delete();
			results_seen  = 0;
			fail_count    = 0;
			pending       = 0;
			branches_seen = 0;
			miss_count    = 0;
			gshare_count  = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					hgbp_pkg::REG_MODE:         mode_r = cfg_data[1:0];
					hgbp_pkg::REG_CHOOSER_BITS: chooser_bits_r = cfg_data;
					hgbp_pkg::REG_GSHARE_BITS:  gshare_bits_r = cfg_data;
					hgbp_pkg::REG_HISTORY_BITS: history_bits_r = cfg_data;
					hgbp_pkg::REG_BIMODAL_BITS: bimodal_bits_r = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.predicted_taken = m_axis_tdata[0];
				got.mispredicted    = m_axis_tdata[1];
				got.used_gshare     = m_axis_tdata[2];
				if (result_q.size() == 0) begin
					note_failure($sformatf("result beat %0d with no branch outstanding: %b",
					                       results_seen, m_axis_tdata[2:0]));
				end else begin
					want = result_q.pop_front();
					if (got.predicted_taken !== want.predicted_taken ||
					    got.mispredicted !== want.mispredicted ||
					    got.used_gshare !== want.used_gshare)
						note_failure($sformatf({"result beat %0d: expected taken=%b miss=%b ",
						                        "gshare=%b, got taken=%b miss=%b gshare=%b"},
						                       results_seen, want.predicted_taken,
						                       want.mispredicted, want.used_gshare,
						                       got.predicted_taken, got.mispredicted,
						                       got.used_gshare));
				end
				results_seen++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want = predict_and_train(s_axis_tdata[31:0], s_axis_tdata[32]);
				result_q.push_back(want);
				branches_seen++;
				if (want.mispredicted)
					miss_count++;
				if (want.used_gshare)
					gshare_count++;
			end
			pending = result_q.size();
		end
	end

endmodule

@@ tb/tb_hybrid_gshare_bimodal_predictor.sv @@
`timescale 1ns / 1ps

module tb_hybrid_gshare_bimodal_predictor;

	localparam int unsigned MAX_INDEX_BITS = 12;
	// bound on the whole run, incl. the table sweep and the long hold-offs
	localparam int unsigned CYCLE_LIMIT = 250000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PHASE_ITEMS = 125;
	localparam int unsigned POOL_SIZE = 16;
	localparam int unsigned HOLD_AT_ITEM = 40;
	// mode code the block does not define, expected to act as hybrid
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// how a branch in the address pool behaves
	typedef enum int unsigned {
		LOOP_EXIT,     // taken except once per trip count
		ALWAYS_TAKEN,
		NEVER_TAKEN,
		COIN_FLIP
	} habit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;   // [31:0] branch_address, [32] taken, rest zero
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // [0] predicted_taken, [1] mispredicted,
	                                  // [2] used_gshare, rest zero
	logic                            cfg_we = 1'b0;
	logic [hgbp_pkg::REG_ADDR_W-1:0] cfg_addr = '0;
	logic [hgbp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count;
	int pending;
	int branches_seen;
	int miss_count;
	int gshare_count;

	int unsigned cycles = 0;
	int unsigned settings_run = 0;
	bit tx_bursty = 1'b0;   // sender offers beats back to back
	bit rx_eager = 1'b0;    // receiver never stalls
	bit hold_req = 1'b0;    // asks the receiver for one long hold-off

	logic [31:0] pool_addr [POOL_SIZE];
	habit_t      pool_habit [POOL_SIZE];
	int unsigned pool_period [POOL_SIZE];
	int unsigned pool_trip [POOL_SIZE];

	hybrid_gshare_bimodal_predictor #(
		.MAX_INDEX_BITS(MAX_INDEX_BITS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data)
	);

	// predicts every accepted branch and compares every result beat
	hgbp_branch_checker #(
		.MAX_INDEX_BITS(MAX_INDEX_BITS)
	) branch_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.branches_seen(branches_seen),
		.miss_count   (miss_count),
		.gshare_count (gshare_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	// one register write per clock, enable stays up across a burst of writes
	task automatic write_reg(input logic [hgbp_pkg::REG_ADDR_W-1:0] idx,
	                         input logic [3:0] val);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_predictor(input logic [3:0] mode_code, input logic [3:0] k,
	                             input logic [3:0] m1, input logic [3:0] n,
	                             input logic [3:0] m2);
		write_reg(hgbp_pkg::REG_MODE, mode_code);
		write_reg(hgbp_pkg::REG_CHOOSER_BITS, k);
		write_reg(hgbp_pkg::REG_GSHARE_BITS, m1);
		write_reg(hgbp_pkg::REG_HISTORY_BITS, n);
		write_reg(hgbp_pkg::REG_BIMODAL_BITS, m2);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	// gap drawn per beat, then hold the beat until the block takes it
	task automatic send_branch(input logic [31:0] addr, input logic tkn);
		int unsigned gap;
		gap = tx_bursty ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, tkn, addr};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// stop offering and wait for every outstanding result beat
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		// let the checker log the last accepted branch first
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	// one predictor setting: new address pool, mostly patterned branches
	task automatic run_phase(input logic [3:0] mode_code, input logic [3:0] k,
	                         input logic [3:0] m1, input logic [3:0] n,
	                         input logic [3:0] m2, input bit with_hold);
		int unsigned pick;
		int unsigned slot;
		logic [31:0] addr;
		logic tkn;
		drain;
		set_predictor(mode_code, k, m1, n, m2);
		tx_bursty = with_hold || (settings_run % 3 == 0);
		rx_eager  = !with_hold && (settings_run % 4 == 1);
		for (int i = 0; i < POOL_SIZE; i++) begin
			// the last few alias the first ones: same low bits, other upper bits
			if (i >= POOL_SIZE - 4)
				pool_addr[i] = pool_addr[i - (POOL_SIZE - 4)] ^ ($urandom() << 14);
			else
				pool_addr[i] = $urandom();
			pool_habit[i]  = habit_t'($urandom_range(0, 3));
			pool_period[i] = $urandom_range(2, 6);
			pool_trip[i]   = 0;
		end
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				slot = $urandom_range(0, POOL_SIZE - 1);
				addr = pool_addr[slot];
				case (pool_habit[slot])
					LOOP_EXIT:    tkn = (pool_trip[slot] % pool_period[slot]) !=
					                    pool_period[slot] - 1;
					ALWAYS_TAKEN: tkn = 1'b1;
					NEVER_TAKEN:  tkn = 1'b0;
					default:      tkn = 1'($urandom_range(0, 1));
				endcase
				pool_trip[slot]++;
			end else begin
				addr = $urandom();
				tkn  = 1'($urandom_range(0, 1));
			end
			if (with_hold && i == HOLD_AT_ITEM)
				hold_req = 1'b1;
			send_branch(addr, tkn);
		end
	endtask

	// result side: per-beat stall, plus one long hold-off when asked
	initial begin : receiver
		int unsigned stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = rx_eager ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin : watchdog
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// writes land during the table sweep; unused indexes must be ignored
		for (int a = hgbp_pkg::REG_BIMODAL_BITS + 1; a < (1 << hgbp_pkg::REG_ADDR_W); a++)
			write_reg(a[hgbp_pkg::REG_ADDR_W-1:0], 4'($urandom_range(0, 15)));
		set_predictor(4'(hgbp_pkg::MODE_HYBRID), 4'd8, 4'd9, 4'd6, 4'd7);

		// directed part at the reset setting, back to back for forwarding
		tx_bursty = 1'b1;
		send_branch(32'h0000_0000, 1'b0);
		send_branch(32'hffff_ffff, 1'b1);
		send_branch(32'hffff_fffc, 1'b0);
		send_branch(32'h0000_0003, 1'b1);   // byte offset ignored, same entries as 0
		repeat (4) send_branch(32'h0000_0100, 1'b1);   // saturate up
		repeat (5) send_branch(32'h0000_0100, 1'b0);   // and all the way down
		// flip-flopping branch makes the components disagree and moves the chooser
		for (int i = 0; i < 6; i++)
			send_branch(32'h0000_0040, i[0]);
		// same bimodal entry from different upper address bits
		send_branch(32'h0000_0010, 1'b1);
		send_branch(32'h0000_0210, 1'b0);
		send_branch(32'h8000_0010, 1'b1);
		send_branch(32'h0000_0210, 1'b0);

		run_phase(4'(hgbp_pkg::MODE_HYBRID),  4'd8,  4'd9,  4'd6,  4'd7,  1'b0);
		run_phase(4'(hgbp_pkg::MODE_BIMODAL), 4'd3,  4'd4,  4'd4,  4'd2,  1'b1);
		run_phase(4'(hgbp_pkg::MODE_GSHARE),  4'd5,  4'd6,  4'd6,  4'd5,  1'b0);
		run_phase(4'(MODE_SPARE),             4'd4,  4'd5,  4'd3,  4'd4,  1'b0);
		// widths beyond the table size saturate
		run_phase(4'(hgbp_pkg::MODE_HYBRID),  4'd15, 4'd15, 4'd15, 4'd15, 1'b0);
		// zero widths: every lookup hits entry 0, history stays clear
		run_phase(4'(hgbp_pkg::MODE_HYBRID),  4'd0,  4'd0,  4'd0,  4'd0,  1'b0);
		run_phase(4'(hgbp_pkg::MODE_HYBRID),  4'd12, 4'd12, 4'd12, 4'd12, 1'b0);
		// shorter history right after a full one leaves stale upper bits
		run_phase(4'(hgbp_pkg::MODE_GSHARE),  4'd0,  4'd8,  4'd2,  4'd0,  1'b1);
		// history longer than the gshare index gets cut down
		run_phase(4'(hgbp_pkg::MODE_HYBRID),  4'd2,  4'd3,  4'd9,  4'd3,  1'b0);
		run_phase(4'(hgbp_pkg::MODE_HYBRID),  4'd13, 4'd1,  4'd1,  4'd14, 1'b0);
		// random settings, mode data with junk in its upper bits too
		repeat (3)
			run_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
			          4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
			          4'($urandom_range(0, 15)), 1'b0);

		drain;
		// a few quiet cycles to catch any stray result beat
		repeat (8) @(posedge clk);
		$display("ran %0d branches over %0d predictor settings, every mode code,",
		         branches_seen, settings_run);
		$display("widths from zero to past the table size, long output stalls");
		$display("%0d mispredicted, %0d predicted by gshare, %0d failures",
		         miss_count, gshare_count, fail_count);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
